/* rtl/core/rtc_pkg.sv */
package rtc_pkg;

    localparam int unsigned TimerW = 15;
    localparam int unsigned TickW = 8;
    localparam int unsigned SecW = 12;
    localparam int unsigned PhaseW = 6;
    localparam int unsigned AddrW = 5;
    localparam int unsigned DataW = 32;

    localparam logic [TimerW-1:0] TIMER_MAX = 15'h7FFF;
    localparam logic [SecW-1:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [PhaseW-1:0] LAST_SEC_OF_MIN = 6'd59;

    localparam logic [7:0] FRAME_HDR0 = 8'hF0;
    localparam logic [7:0] FRAME_HDR1 = 8'h00;
    localparam logic [7:0] FRAME_TRAIL = 8'h0F;
    localparam logic [7:0] CMD_ON = 8'h11;
    localparam logic [7:0] CMD_OFF = 8'h22;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_RX_TIMEOUT = 2'd1;
    localparam logic [1:0] KIND_CONTROL = 2'd2;

    localparam logic [2:0] REG_PULSE_MODE = 3'd0;
    localparam logic [2:0] REG_CYCLE_MODE = 3'd1;
    localparam logic [2:0] REG_COLD_FORCE = 3'd2;
    localparam logic [2:0] REG_PULSE_SECONDS = 3'd3;
    localparam logic [2:0] REG_ON_WAIT = 3'd4;
    localparam logic [2:0] REG_OFF_WAIT = 3'd5;
    localparam logic [2:0] REG_COLD_THRESHOLD = 3'd6;
    localparam logic [2:0] REG_TICKS_PER_SEC = 3'd7;

    localparam logic signed [7:0] COLD_THRESHOLD_RST = 8'sd20;
    localparam logic [TickW-1:0] TICKS_PER_SEC_RST = 8'd28;

    typedef struct packed {
        logic pulse_mode_enable;
        logic cycle_mode_enable;
        logic cold_force_enable;
        logic [TimerW-1:0] pulse_seconds;
        logic [TimerW-1:0] on_wait_minutes;
        logic [TimerW-1:0] off_wait_minutes;
        logic signed [7:0] cold_threshold;
        logic [TickW-1:0] ticks_per_second;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic frame_ready;
        logic [7:0] frame_byte0;
        logic [7:0] frame_byte1;
        logic [7:0] frame_command;
        logic [7:0] frame_byte3;
        logic signed [7:0] temperature;
        logic and_input_a;
        logic and_input_b;
        logic or_input_a;
        logic or_input_b;
    } item_t;

    typedef struct packed {
        logic relay1;
        logic relay2;
        logic relay3;
        logic relay4;
        logic second_pulse;
        logic minute_pulse;
        logic hour_pulse;
    } result_t;

    function automatic logic [TimerW-1:0] sat_inc(input logic [TimerW-1:0] t);
        sat_inc = (t == TIMER_MAX) ? t : t + 15'd1;
    endfunction

endpackage

/* rtl/core/rtc_regs.sv */
module rtc_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rtc_pkg::AddrW-1:0]  paddr,
    input  logic [rtc_pkg::DataW-1:0]  pwdata,
    output logic [rtc_pkg::DataW-1:0]  prdata,
    output logic                       pready,
    output rtc_pkg::cfg_t              cfg
);

    rtc_pkg::cfg_t cfg_reg;
    logic [2:0] index;
    logic wr_en;

    assign index = paddr[4:2];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_mode_enable <= 1'b0;
            cfg_reg.cycle_mode_enable <= 1'b0;
            cfg_reg.cold_force_enable <= 1'b0;
            cfg_reg.pulse_seconds <= '0;
            cfg_reg.on_wait_minutes <= '0;
            cfg_reg.off_wait_minutes <= '0;
            cfg_reg.cold_threshold <= rtc_pkg::COLD_THRESHOLD_RST;
            cfg_reg.ticks_per_second <= rtc_pkg::TICKS_PER_SEC_RST;
        end
        else if (wr_en)
        begin
            unique case (index)
                rtc_pkg::REG_PULSE_MODE:     cfg_reg.pulse_mode_enable <= pwdata[0];
                rtc_pkg::REG_CYCLE_MODE:     cfg_reg.cycle_mode_enable <= pwdata[0];
                rtc_pkg::REG_COLD_FORCE:     cfg_reg.cold_force_enable <= pwdata[0];
                rtc_pkg::REG_PULSE_SECONDS:  cfg_reg.pulse_seconds <= pwdata[14:0];
                rtc_pkg::REG_ON_WAIT:        cfg_reg.on_wait_minutes <= pwdata[14:0];
                rtc_pkg::REG_OFF_WAIT:       cfg_reg.off_wait_minutes <= pwdata[14:0];
                rtc_pkg::REG_COLD_THRESHOLD: cfg_reg.cold_threshold <= pwdata[7:0];
                rtc_pkg::REG_TICKS_PER_SEC:  cfg_reg.ticks_per_second <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (index)
            rtc_pkg::REG_PULSE_MODE:     prdata[0] = cfg_reg.pulse_mode_enable;
            rtc_pkg::REG_CYCLE_MODE:     prdata[0] = cfg_reg.cycle_mode_enable;
            rtc_pkg::REG_COLD_FORCE:     prdata[0] = cfg_reg.cold_force_enable;
            rtc_pkg::REG_PULSE_SECONDS:  prdata[14:0] = cfg_reg.pulse_seconds;
            rtc_pkg::REG_ON_WAIT:        prdata[14:0] = cfg_reg.on_wait_minutes;
            rtc_pkg::REG_OFF_WAIT:       prdata[14:0] = cfg_reg.off_wait_minutes;
            rtc_pkg::REG_COLD_THRESHOLD: prdata[7:0] = cfg_reg.cold_threshold;
            rtc_pkg::REG_TICKS_PER_SEC:  prdata[7:0] = cfg_reg.ticks_per_second;
            default: ;
        endcase
    end

endmodule

/* rtl/core/rtc_engine.sv */
module rtc_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  rtc_pkg::item_t   item,
    input  rtc_pkg::cfg_t    cfg,
    output rtc_pkg::result_t result
);

    logic [rtc_pkg::TickW-1:0]  tick_count_reg, tick_count_next;
    logic [rtc_pkg::SecW-1:0]   second_count_reg, second_count_next;
    logic [rtc_pkg::PhaseW-1:0] minute_phase_reg, minute_phase_next;
    logic second_flag_reg, second_flag_next;
    logic minute_flag_reg, minute_flag_next;
    logic hour_flag_reg, hour_flag_next;
    logic command_latch_reg, command_latch_next;
    logic [rtc_pkg::TimerW-1:0] pulse_timer_reg, pulse_timer_next;
    logic [rtc_pkg::TimerW-1:0] cycle_timer_reg, cycle_timer_next;
    logic [3:0] relay_reg, relay_next;

    logic [rtc_pkg::TickW-1:0] tick_inc;
    logic [rtc_pkg::SecW-1:0]  sec_inc;
    logic frame_ok;
    logic s_out, m_out, h_out;

    always_comb
    begin
        tick_count_next = tick_count_reg;
        second_count_next = second_count_reg;
        minute_phase_next = minute_phase_reg;
        second_flag_next = second_flag_reg;
        minute_flag_next = minute_flag_reg;
        hour_flag_next = hour_flag_reg;
        command_latch_next = command_latch_reg;
        pulse_timer_next = pulse_timer_reg;
        cycle_timer_next = cycle_timer_reg;
        relay_next = relay_reg;

        tick_inc = tick_count_reg + 8'd1;
        sec_inc = second_count_reg + 12'd1;
        frame_ok = item.frame_ready && (item.frame_byte0 == rtc_pkg::FRAME_HDR0)
            && (item.frame_byte1 == rtc_pkg::FRAME_HDR1)
            && (item.frame_byte3 == rtc_pkg::FRAME_TRAIL);

        if (item.kind == rtc_pkg::KIND_TICK)
        begin
            tick_count_next = tick_inc;
            if (tick_inc >= cfg.ticks_per_second)
            begin
                tick_count_next = '0;
                second_count_next = sec_inc;
                second_flag_next = 1'b1;
                if (minute_phase_reg == rtc_pkg::LAST_SEC_OF_MIN)
                begin
                    minute_phase_next = '0;
                    minute_flag_next = 1'b1;
                end
                else
                begin
                    minute_phase_next = minute_phase_reg + 6'd1;
                end
                if (sec_inc == rtc_pkg::SECS_PER_HOUR)
                begin
                    hour_flag_next = 1'b1;
                    second_count_next = '0;
                end
            end
        end
        else if (item.kind == rtc_pkg::KIND_RX_TIMEOUT)
        begin
            command_latch_next = 1'b0;
        end
        else if (item.kind == rtc_pkg::KIND_CONTROL)
        begin
            if (frame_ok)
            begin
                if (item.frame_command == rtc_pkg::CMD_ON && !command_latch_reg)
                begin
                    relay_next[0] = 1'b1;
                    command_latch_next = 1'b1;
                end
                else if (item.frame_command == rtc_pkg::CMD_OFF)
                begin
                    relay_next[0] = 1'b0;
                end
            end

            if (cfg.pulse_mode_enable && relay_next[0])
            begin
                if (second_flag_reg)
                    pulse_timer_next = rtc_pkg::sat_inc(pulse_timer_reg);
                if (pulse_timer_next > cfg.pulse_seconds)
                begin
                    relay_next[0] = 1'b0;
                    pulse_timer_next = '0;
                end
            end

            if (cfg.cycle_mode_enable)
            begin
                if (minute_flag_reg)
                    cycle_timer_next = rtc_pkg::sat_inc(cycle_timer_reg);
                if (cfg.cold_force_enable && (item.temperature <= cfg.cold_threshold)
                    && !relay_next[1])
                begin
                    relay_next[1] = 1'b1;
                    cycle_timer_next = '0;
                end
                if (!relay_next[1])
                begin
                    if (cycle_timer_next >= cfg.on_wait_minutes)
                    begin
                        relay_next[1] = 1'b1;
                        cycle_timer_next = '0;
                    end
                end
                else if (cycle_timer_next >= cfg.off_wait_minutes)
                begin
                    relay_next[1] = 1'b0;
                    cycle_timer_next = '0;
                end
            end

            relay_next[2] = item.and_input_a && item.and_input_b;
            relay_next[3] = item.or_input_a || item.or_input_b;
        end

        s_out = second_flag_next;
        m_out = minute_flag_next;
        h_out = hour_flag_next;
        if (item.kind == rtc_pkg::KIND_CONTROL)
        begin
            second_flag_next = 1'b0;
            minute_flag_next = 1'b0;
            hour_flag_next = 1'b0;
        end

        result.relay1 = relay_next[0];
        result.relay2 = relay_next[1];
        result.relay3 = relay_next[2];
        result.relay4 = relay_next[3];
        result.second_pulse = s_out;
        result.minute_pulse = m_out;
        result.hour_pulse = h_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            second_count_reg <= '0;
            minute_phase_reg <= '0;
            second_flag_reg <= 1'b0;
            minute_flag_reg <= 1'b0;
            hour_flag_reg <= 1'b0;
            command_latch_reg <= 1'b0;
            pulse_timer_reg <= '0;
            cycle_timer_reg <= '0;
            relay_reg <= '0;
        end
        else if (step)
        begin
            tick_count_reg <= tick_count_next;
            second_count_reg <= second_count_next;
            minute_phase_reg <= minute_phase_next;
            second_flag_reg <= second_flag_next;
            minute_flag_reg <= minute_flag_next;
            hour_flag_reg <= hour_flag_next;
            command_latch_reg <= command_latch_next;
            pulse_timer_reg <= pulse_timer_next;
            cycle_timer_reg <= cycle_timer_next;
            relay_reg <= relay_next;
        end
    end

    // A control pass always leaves every pulse flag cleared.
    a_control_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.kind == rtc_pkg::KIND_CONTROL
        |=> !second_flag_reg && !minute_flag_reg && !hour_flag_reg)
        else $error("pulse flags not cleared by control pass");

    // An hour boundary restarts both the second count and the minute phase.
    a_hour_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hour_flag_reg) |-> second_count_reg == '0 && minute_phase_reg == '0)
        else $error("hour flag without second count wrap");

    // A receiver timeout always drops the command latch.
    a_timeout_latch: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.kind == rtc_pkg::KIND_RX_TIMEOUT |=> !command_latch_reg)
        else $error("command latch survived receiver timeout");

    // The second count stays inside one hour.
    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> second_count_reg < rtc_pkg::SECS_PER_HOUR)
        else $error("second count out of range");

endmodule

/* rtl/core/relay_timer_controller.sv */
// An accepted item waits in the input register until the result register is free.
// Throughput: one item per cycle while out_ready does not stall; the two registers
// let a new item enter while a finished result still waits to be taken.
// Reset (rst_n low, asynchronous) clears the relay state, counters, timers, flags and
// the command latch, and loads the register defaults; the result register is not reset.
module relay_timer_controller (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rtc_pkg::AddrW-1:0]  paddr,
    input  logic [rtc_pkg::DataW-1:0]  pwdata,
    output logic [rtc_pkg::DataW-1:0]  prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 kind,
    input  logic                       frame_ready,
    input  logic [7:0]                 frame_byte0,
    input  logic [7:0]                 frame_byte1,
    input  logic [7:0]                 frame_command,
    input  logic [7:0]                 frame_byte3,
    input  logic signed [7:0]          temperature,
    input  logic                       and_input_a,
    input  logic                       and_input_b,
    input  logic                       or_input_a,
    input  logic                       or_input_b,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       relay1,
    output logic                       relay2,
    output logic                       relay3,
    output logic                       relay4,
    output logic                       second_pulse,
    output logic                       minute_pulse,
    output logic                       hour_pulse
);

    rtc_pkg::cfg_t cfg;
    rtc_pkg::item_t item_reg;
    rtc_pkg::result_t result, result_reg;
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic advance;

    assign out_free = !out_valid_reg || out_ready;
    assign advance = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;

    rtc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rtc_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.kind <= kind;
            item_reg.frame_ready <= frame_ready;
            item_reg.frame_byte0 <= frame_byte0;
            item_reg.frame_byte1 <= frame_byte1;
            item_reg.frame_command <= frame_command;
            item_reg.frame_byte3 <= frame_byte3;
            item_reg.temperature <= temperature;
            item_reg.and_input_a <= and_input_a;
            item_reg.and_input_b <= and_input_b;
            item_reg.or_input_a <= or_input_a;
            item_reg.or_input_b <= or_input_b;
        end
        if (advance)
            result_reg <= result;
    end

    assign relay1 = result_reg.relay1;
    assign relay2 = result_reg.relay2;
    assign relay3 = result_reg.relay3;
    assign relay4 = result_reg.relay4;
    assign second_pulse = result_reg.second_pulse;
    assign minute_pulse = result_reg.minute_pulse;
    assign hour_pulse = result_reg.hour_pulse;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned SECS_PER_MIN = 60;
    localparam int unsigned LATENCY = 1;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_REPORTS = 10;

    class relay_scoreboard;
        rtc_pkg::cfg_t regs;
        logic [rtc_pkg::TickW-1:0] ticks;
        logic [rtc_pkg::SecW-1:0] seconds;
        logic sec_flag;
        logic min_flag;
        logic hour_flag;
        logic latch;
        logic [rtc_pkg::TimerW-1:0] pulse_time;
        logic [rtc_pkg::TimerW-1:0] cycle_time;
        logic [3:0] relays;
        rtc_pkg::result_t expected_relays[$];
        int unsigned mismatches;

        function new();
            regs = '0;
            regs.cold_threshold = rtc_pkg::COLD_THRESHOLD_RST;
            regs.ticks_per_second = rtc_pkg::TICKS_PER_SEC_RST;
            ticks = '0;
            seconds = '0;
            sec_flag = 1'b0;
            min_flag = 1'b0;
            hour_flag = 1'b0;
            latch = 1'b0;
            pulse_time = '0;
            cycle_time = '0;
            relays = '0;
            mismatches = 0;
        endfunction

        function void write_reg(input logic [2:0] idx,
                                input logic [rtc_pkg::DataW-1:0] value);
            case (idx)
                rtc_pkg::REG_PULSE_MODE: regs.pulse_mode_enable = value[0];
                rtc_pkg::REG_CYCLE_MODE: regs.cycle_mode_enable = value[0];
                rtc_pkg::REG_COLD_FORCE: regs.cold_force_enable = value[0];
                rtc_pkg::REG_PULSE_SECONDS: regs.pulse_seconds = value[rtc_pkg::TimerW-1:0];
                rtc_pkg::REG_ON_WAIT: regs.on_wait_minutes = value[rtc_pkg::TimerW-1:0];
                rtc_pkg::REG_OFF_WAIT: regs.off_wait_minutes = value[rtc_pkg::TimerW-1:0];
                rtc_pkg::REG_COLD_THRESHOLD: regs.cold_threshold = value[7:0];
                rtc_pkg::REG_TICKS_PER_SEC: regs.ticks_per_second = value[rtc_pkg::TickW-1:0];
                default: ;
            endcase
        endfunction

        function logic [rtc_pkg::TimerW-1:0] bump(input logic [rtc_pkg::TimerW-1:0] t);
            return (&t) ? t : t + 1'b1;
        endfunction

        function void count_tick();
            ticks = ticks + 1'b1;
            if (ticks >= regs.ticks_per_second)
            begin
                ticks = '0;
                seconds = seconds + 1'b1;
                sec_flag = 1'b1;
                if (seconds % SECS_PER_MIN == 0)
                begin
                    min_flag = 1'b1;
                end
                if (seconds == rtc_pkg::SECS_PER_HOUR)
                begin
                    hour_flag = 1'b1;
                    seconds = '0;
                end
            end
        endfunction

        function void run_control(input rtc_pkg::item_t it);
            if (it.frame_ready && it.frame_byte0 == rtc_pkg::FRAME_HDR0
                && it.frame_byte1 == rtc_pkg::FRAME_HDR1
                && it.frame_byte3 == rtc_pkg::FRAME_TRAIL)
            begin
                if (it.frame_command == rtc_pkg::CMD_ON && !latch)
                begin
                    relays[0] = 1'b1;
                    latch = 1'b1;
                end
                else if (it.frame_command == rtc_pkg::CMD_OFF)
                begin
                    relays[0] = 1'b0;
                end
            end
            if (regs.pulse_mode_enable && relays[0])
            begin
                if (sec_flag)
                begin
                    pulse_time = bump(pulse_time);
                end
                if (pulse_time > regs.pulse_seconds)
                begin
                    relays[0] = 1'b0;
                    pulse_time = '0;
                end
            end
            if (regs.cycle_mode_enable)
            begin
                if (min_flag)
                begin
                    cycle_time = bump(cycle_time);
                end
                // Cold forcing does not skip the off check that follows.
                if (regs.cold_force_enable && !relays[1]
                    && $signed(it.temperature) <= $signed(regs.cold_threshold))
                begin
                    relays[1] = 1'b1;
                    cycle_time = '0;
                end
                if (!relays[1])
                begin
                    if (cycle_time >= regs.on_wait_minutes)
                    begin
                        relays[1] = 1'b1;
                        cycle_time = '0;
                    end
                end
                else if (cycle_time >= regs.off_wait_minutes)
                begin
                    relays[1] = 1'b0;
                    cycle_time = '0;
                end
            end
            relays[2] = it.and_input_a & it.and_input_b;
            relays[3] = it.or_input_a | it.or_input_b;
        endfunction

        function void take_item(input rtc_pkg::item_t it);
            rtc_pkg::result_t r;
            case (it.kind)
                rtc_pkg::KIND_TICK: count_tick();
                rtc_pkg::KIND_RX_TIMEOUT: latch = 1'b0;
                rtc_pkg::KIND_CONTROL: run_control(it);
                default: ;
            endcase
            r.relay1 = relays[0];
            r.relay2 = relays[1];
            r.relay3 = relays[2];
            r.relay4 = relays[3];
            r.second_pulse = sec_flag;
            r.minute_pulse = min_flag;
            r.hour_pulse = hour_flag;
            if (it.kind == rtc_pkg::KIND_CONTROL)
            begin
                sec_flag = 1'b0;
                min_flag = 1'b0;
                hour_flag = 1'b0;
            end
            expected_relays.push_back(r);
        endfunction

        function void check_result(input rtc_pkg::result_t got);
            rtc_pkg::result_t want;
            if (expected_relays.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t: result with none expected: relays %b%b%b%b pulses %b%b%b",
                             $realtime, got.relay1, got.relay2, got.relay3, got.relay4,
                             got.second_pulse, got.minute_pulse, got.hour_pulse);
                end
                return;
            end
            want = expected_relays.pop_front();
            if (got.relay1 !== want.relay1 || got.relay2 !== want.relay2
                || got.relay3 !== want.relay3 || got.relay4 !== want.relay4
                || got.second_pulse !== want.second_pulse
                || got.minute_pulse !== want.minute_pulse
                || got.hour_pulse !== want.hour_pulse)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t: relays 1-4 expected %b%b%b%b got %b%b%b%b", $realtime,
                             want.relay1, want.relay2, want.relay3, want.relay4,
                             got.relay1, got.relay2, got.relay3, got.relay4);
                    $display("%0t: pulses s/m/h expected %b%b%b got %b%b%b", $realtime,
                             want.second_pulse, want.minute_pulse, want.hour_pulse,
                             got.second_pulse, got.minute_pulse, got.hour_pulse);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [rtc_pkg::AddrW-1:0] paddr = '0;
    logic [rtc_pkg::DataW-1:0] pwdata = '0;
    logic [rtc_pkg::DataW-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    rtc_pkg::item_t stim = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic relay1;
    logic relay2;
    logic relay3;
    logic relay4;
    logic second_pulse;
    logic minute_pulse;
    logic hour_pulse;

    bit rx_steady = 1'b0;
    bit rx_next;
    int unsigned rx_run = 0;
    int unsigned rx_hold = 0;
    int unsigned cycles = 0;

    relay_scoreboard sb;

    relay_timer_controller dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(stim.kind),
        .frame_ready(stim.frame_ready),
        .frame_byte0(stim.frame_byte0),
        .frame_byte1(stim.frame_byte1),
        .frame_command(stim.frame_command),
        .frame_byte3(stim.frame_byte3),
        .temperature(stim.temperature),
        .and_input_a(stim.and_input_a),
        .and_input_b(stim.and_input_b),
        .or_input_a(stim.or_input_a),
        .or_input_b(stim.or_input_b),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .relay1(relay1),
        .relay2(relay2),
        .relay3(relay3),
        .relay4(relay4),
        .second_pulse(second_pulse),
        .minute_pulse(minute_pulse),
        .hour_pulse(hour_pulse)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rx_steady)
        begin
            rx_next = 1'b1;
        end
        else if (rx_run > 0)
        begin
            rx_next = 1'b1;
            rx_run--;
        end
        else if (rx_hold > 0)
        begin
            rx_next = 1'b0;
            rx_hold--;
        end
        else
        begin
            rx_run = $urandom_range(1, 12);
            rx_hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            rx_next = 1'b1;
        end
        out_ready <= rx_next;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_result(rtc_pkg::result_t'({relay1, relay2, relay3, relay4,
                                                    second_pulse, minute_pulse,
                                                    hour_pulse}));
            end
            if (in_valid && in_ready)
            begin
                sb.take_item(stim);
            end
        end
    end

    function automatic rtc_pkg::item_t mk(input logic [1:0] k, input logic rdy,
                                          input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] cmd, input logic [7:0] b3,
                                          input logic signed [7:0] temp,
                                          input logic [3:0] ins);
        rtc_pkg::item_t it;
        it.kind = k;
        it.frame_ready = rdy;
        it.frame_byte0 = b0;
        it.frame_byte1 = b1;
        it.frame_command = cmd;
        it.frame_byte3 = b3;
        it.temperature = temp;
        {it.and_input_a, it.and_input_b, it.or_input_a, it.or_input_b} = ins;
        return it;
    endfunction

    function automatic rtc_pkg::item_t random_item(input int unsigned tick_pct);
        rtc_pkg::item_t it;
        int unsigned sel;
        it = mk(rtc_pkg::KIND_CONTROL, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'(int'($urandom_range(0, 165)) - 40),
                4'($urandom_range(0, 15)));
        if ($urandom_range(0, 99) < tick_pct)
        begin
            it.kind = rtc_pkg::KIND_TICK;
        end
        else
        begin
            sel = $urandom_range(0, 19);
            if (sel < 3)
            begin
                it.kind = rtc_pkg::KIND_RX_TIMEOUT;
            end
            else if (sel == 3)
            begin
                it.kind = KIND_UNUSED;
            end
        end
        // Most control passes carry a well-formed frame so the relay logic is reached.
        if (it.kind == rtc_pkg::KIND_CONTROL && $urandom_range(0, 9) < 7)
        begin
            it.frame_ready = 1'b1;
            it.frame_byte0 = rtc_pkg::FRAME_HDR0;
            it.frame_byte1 = rtc_pkg::FRAME_HDR1;
            it.frame_byte3 = rtc_pkg::FRAME_TRAIL;
            sel = $urandom_range(0, 9);
            if (sel < 4)
            begin
                it.frame_command = rtc_pkg::CMD_ON;
            end
            else if (sel < 8)
            begin
                it.frame_command = rtc_pkg::CMD_OFF;
            end
        end
        return it;
    endfunction

    task automatic send_item(input rtc_pkg::item_t it);
        stim <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_cycles(input int unsigned n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_relays.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input int unsigned value);
        paddr <= rtc_pkg::AddrW'({idx, 2'b00});
        pwdata <= rtc_pkg::DataW'(value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        sb.write_reg(idx, rtc_pkg::DataW'(value));
    endtask

    task automatic program_regs(input bit pm, input bit cm, input bit cf,
                                input int unsigned ps, input int unsigned onw,
                                input int unsigned offw, input int thr,
                                input int unsigned tps);
        wait_drained();
        apb_write(rtc_pkg::REG_PULSE_MODE, pm);
        apb_write(rtc_pkg::REG_CYCLE_MODE, cm);
        apb_write(rtc_pkg::REG_COLD_FORCE, cf);
        apb_write(rtc_pkg::REG_PULSE_SECONDS, ps);
        apb_write(rtc_pkg::REG_ON_WAIT, onw);
        apb_write(rtc_pkg::REG_OFF_WAIT, offw);
        apb_write(rtc_pkg::REG_COLD_THRESHOLD, unsigned'(thr) & 32'hFF);
        apb_write(rtc_pkg::REG_TICKS_PER_SEC, tps);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random(input int unsigned count, input int unsigned tick_pct,
                               input bit bursty);
        int unsigned burst_left;
        burst_left = $urandom_range(1, 24);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (bursty && burst_left == 0)
            begin
                idle_cycles($urandom_range(1, 8));
                burst_left = $urandom_range(1, 24);
            end
            if ($urandom_range(0, 149) == 0)
            begin
                wait_drained();
            end
            send_item(random_item(tick_pct));
            if (burst_left > 0)
            begin
                burst_left--;
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(mk(KIND_UNUSED, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, -8'sd1, 4'hF));
        send_item(mk(rtc_pkg::KIND_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'sd0, 4'h0));
        send_item(mk(rtc_pkg::KIND_CONTROL, 1'b1, rtc_pkg::FRAME_HDR0, rtc_pkg::FRAME_HDR1,
                     rtc_pkg::CMD_ON, rtc_pkg::FRAME_TRAIL, -8'sd40, 4'hF));
        send_item(mk(rtc_pkg::KIND_CONTROL, 1'b1, rtc_pkg::FRAME_HDR0, rtc_pkg::FRAME_HDR1,
                     rtc_pkg::CMD_ON, rtc_pkg::FRAME_TRAIL, 8'sd20, 4'h0));
        send_item(mk(rtc_pkg::KIND_RX_TIMEOUT, 1'b1, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'sd21,
                     4'h6));
        send_item(mk(rtc_pkg::KIND_CONTROL, 1'b1, rtc_pkg::FRAME_HDR0, rtc_pkg::FRAME_HDR1,
                     rtc_pkg::CMD_OFF, rtc_pkg::FRAME_TRAIL, 8'sd19, 4'h8));
        send_item(mk(rtc_pkg::KIND_CONTROL, 1'b1, rtc_pkg::FRAME_HDR0, rtc_pkg::FRAME_HDR1,
                     rtc_pkg::CMD_ON, rtc_pkg::FRAME_TRAIL, 8'sd125, 4'h4));
        send_item(mk(rtc_pkg::KIND_CONTROL, 1'b0, rtc_pkg::FRAME_HDR0, rtc_pkg::FRAME_HDR1,
                     rtc_pkg::CMD_OFF, rtc_pkg::FRAME_TRAIL, 8'sd0, 4'h2));
        send_item(mk(rtc_pkg::KIND_CONTROL, 1'b1, 8'hF1, rtc_pkg::FRAME_HDR1,
                     rtc_pkg::CMD_OFF, rtc_pkg::FRAME_TRAIL, 8'sd0, 4'h1));
        send_item(mk(rtc_pkg::KIND_CONTROL, 1'b1, rtc_pkg::FRAME_HDR0, 8'h01,
                     rtc_pkg::CMD_OFF, rtc_pkg::FRAME_TRAIL, 8'sd0, 4'hA));
        send_item(mk(rtc_pkg::KIND_CONTROL, 1'b1, rtc_pkg::FRAME_HDR0, rtc_pkg::FRAME_HDR1,
                     rtc_pkg::CMD_OFF, 8'h0E, 8'sd0, 4'h5));
        send_item(mk(rtc_pkg::KIND_CONTROL, 1'b1, rtc_pkg::FRAME_HDR0, rtc_pkg::FRAME_HDR1,
                     8'h55, rtc_pkg::FRAME_TRAIL, 8'sd0, 4'hC));
        send_item(mk(rtc_pkg::KIND_CONTROL, 1'b1, rtc_pkg::FRAME_HDR0, rtc_pkg::FRAME_HDR1,
                     rtc_pkg::CMD_OFF, rtc_pkg::FRAME_TRAIL, 8'sd125, 4'h3));
        send_item(mk(rtc_pkg::KIND_CONTROL, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, -8'sd40,
                     4'h9));
        send_item(mk(rtc_pkg::KIND_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'sd125, 4'hF));
        send_item(mk(rtc_pkg::KIND_RX_TIMEOUT, 1'b0, 8'h0F, 8'hF0, 8'h22, 8'h11, -8'sd40,
                     4'h0));

        program_regs(1'b1, 1'b1, 1'b1, 2, 1, 1, 20, 2);
        send_random(180, 45, 1'b1);
        program_regs(1'b1, 1'b1, 1'b0, 0, 0, 0, -40, 0);
        send_random(150, 45, 1'b1);
        program_regs(1'b1, 1'b1, 1'b1, 32767, 32767, 0, 125, 255);
        send_random(150, 45, 1'b1);
        program_regs(1'b0, 1'b0, 1'b1, 5, 3, 2, 0, 1);
        send_random(120, 45, 1'b1);
        rx_steady = 1'b1;
        program_regs(1'b1, 1'b1, 1'b1, 1, 2, 3, 50, 3);
        send_random(120, 45, 1'b0);
        rx_steady = 1'b0;

        // Every tick is a second here, so each control pass sees a second flag.
        program_regs(1'b1, 1'b1, 1'b0, 3, 1, 2, -40, 0);
        repeat (2)
        begin
            send_random(6, 100, 1'b1);
            send_random(1, 0, 1'b0);
        end

        program_regs(1'b0, 1'b1, 1'b1, 7, 0, 32767, -1, 28);
        send_random(100, 45, 1'b1);

        wait_drained();
        if (sb.mismatches == 0 && sb.expected_relays.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/rtc_pkg.sv
rtl/core/rtc_regs.sv
rtl/core/rtc_engine.sv
rtl/core/relay_timer_controller.sv
dv/tb_top.sv
